>>> src/lgfs_pkg.sv
// shared constants, command codes, state type and control structs
// for the led grayscale frame serializer; no dependencies
package lgfs_pkg;

  localparam int MAX_CHIPS         = 8;
  localparam int CHANNELS_PER_CHIP = 24;
  localparam int LEVEL_BITS        = 12;
  localparam int CH_PER_WORD       = 4;
  localparam int WORD_BITS         = CH_PER_WORD * LEVEL_BITS;
  localparam int WORDS_PER_CHIP    = CHANNELS_PER_CHIP / CH_PER_WORD;
  localparam int STORE_DEPTH       = MAX_CHIPS * CHANNELS_PER_CHIP;
  localparam int ROWS              = STORE_DEPTH / CH_PER_WORD;
  localparam int ROW_W             = $clog2(ROWS);
  localparam int LANE_W            = $clog2(CH_PER_WORD);
  localparam int IDX_W             = 8;
  localparam int CHIP_W            = 4;
  localparam int CMD_W             = 2;

  localparam int APB_ADDR_W        = 3;
  localparam int APB_DATA_W        = 32;
  localparam int REG_IDX_W         = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CHIP_COUNT = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_BLANK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic fill_en;
    logic send_start;
    logic blank_set;
    logic word_taken;
    logic report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_row;
  } dp_status_t;

endpackage

>>> src/lgfs_if.sv
// input command channel and output result channel interfaces
// depends on lgfs_pkg
interface lgfs_in_if;
  import lgfs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [IDX_W-1:0]      channel_index;
  logic [LEVEL_BITS-1:0] level;
  logic                  latch_unblank;
  logic                  blank_request;

  modport source (output valid, cmd, channel_index, level, latch_unblank, blank_request,
                  input ready);
  modport sink   (input valid, cmd, channel_index, level, latch_unblank, blank_request,
                  output ready);
endinterface

interface lgfs_out_if;
  import lgfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [WORD_BITS-1:0] frame_word;
  logic                 last;
  logic                 latch_pulse;
  logic                 blank_level;

  modport source (output valid, kind, frame_word, last, latch_pulse, blank_level,
                  input ready);
  modport sink   (input valid, kind, frame_word, last, latch_pulse, blank_level,
                  output ready);
endinterface

>>> src/lgfs_ctrl.sv
// command sequencer: decodes accepted commands and walks the frame send
// depends on lgfs_pkg
module lgfs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [lgfs_pkg::CMD_W-1:0] in_cmd,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  lgfs_pkg::dp_status_t  status,
  output lgfs_pkg::ctrl_cmd_t   ctrl
);
  import lgfs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (cmd_t'(in_cmd))
            CMD_WRITE:  ctrl.wr_en = 1'b1;
            CMD_FILL:   ctrl.fill_en = 1'b1;
            CMD_UPDATE: begin
              ctrl.send_start = 1'b1;
              state_next      = ST_SEND;
            end
            CMD_BLANK: begin
              ctrl.blank_set = 1'b1;
              state_next     = ST_REPORT;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          ctrl.word_taken = 1'b1;
          if (status.last_row) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_REPORT: begin
        out_valid   = 1'b1;
        ctrl.report = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> src/lgfs_datapath.sv
// level store (rows of four channels), fill level, row pointer, blank pin
// and result assembly; depends on lgfs_pkg
module lgfs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  lgfs_pkg::ctrl_cmd_t               ctrl,
  output lgfs_pkg::dp_status_t              status,
  input  logic [lgfs_pkg::CHIP_W-1:0]       chip_count,
  input  logic [lgfs_pkg::IDX_W-1:0]        channel_index,
  input  logic [lgfs_pkg::LEVEL_BITS-1:0]   level,
  input  logic                              latch_unblank,
  input  logic                              blank_request,
  output logic                              kind,
  output logic [lgfs_pkg::WORD_BITS-1:0]    frame_word,
  output logic                              last,
  output logic                              latch_pulse,
  output logic                              blank_level
);
  import lgfs_pkg::*;

  logic [WORD_BITS-1:0]   mem [ROWS];
  logic [CH_PER_WORD-1:0] valid [ROWS];
  logic [WORD_BITS-1:0]   rd_data;
  logic [LEVEL_BITS-1:0]  fill_level;
  logic [ROW_W-1:0]       row;
  logic [ROW_W-1:0]       row_next;
  logic [ROW_W-1:0]       final_row;
  logic [CHIP_W-1:0]      chips;
  logic                   vsync;
  logic                   blank;
  logic                   wr_hit;
  logic [ROW_W-1:0]       wr_row;
  logic [LANE_W-1:0]      wr_lane;
  logic [WORD_BITS-1:0]   merged;

  always_comb begin
    if (chip_count == '0) begin
      chips = CHIP_W'(1);
    end else if (chip_count > CHIP_W'(MAX_CHIPS)) begin
      chips = CHIP_W'(MAX_CHIPS);
    end else begin
      chips = chip_count;
    end
  end

  assign final_row = ROW_W'(32'(chips) * WORDS_PER_CHIP - 1);
  assign wr_hit    = ctrl.wr_en && (channel_index < IDX_W'(STORE_DEPTH));
  assign wr_row    = ROW_W'(channel_index >> LANE_W);
  assign wr_lane   = channel_index[LANE_W-1:0];
  assign status.last_row = (row == '0);

  always_comb begin
    row_next = row;
    if (ctrl.send_start) begin
      row_next = final_row;
    end else if (ctrl.word_taken && !status.last_row) begin
      row_next = row - ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_row][wr_lane*LEVEL_BITS +: LEVEL_BITS] <= level;
    end
    rd_data <= mem[row_next];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.fill_en) begin
      for (int r = 0; r < ROWS; r++) begin
        valid[r] <= '0;
      end
    end else if (wr_hit) begin
      valid[wr_row][wr_lane] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row        <= '0;
      fill_level <= '0;
      blank      <= 1'b1;
      vsync      <= 1'b0;
    end else begin
      row <= row_next;
      if (ctrl.fill_en) begin
        fill_level <= level;
      end
      if (ctrl.send_start) begin
        vsync <= latch_unblank;
      end
      if (ctrl.blank_set) begin
        blank <= blank_request;
      end else if (ctrl.word_taken && status.last_row && vsync) begin
        blank <= 1'b0;
      end
    end
  end

  // channels not written since the last fill read as the fill level
  always_comb begin
    for (int l = 0; l < CH_PER_WORD; l++) begin
      merged[l*LEVEL_BITS +: LEVEL_BITS] = valid[row][l] ?
          rd_data[l*LEVEL_BITS +: LEVEL_BITS] : fill_level;
    end
  end

  assign kind        = ctrl.report;
  assign frame_word  = ctrl.report ? '0 : merged;
  assign last        = ctrl.report || status.last_row;
  assign latch_pulse = !ctrl.report && status.last_row;
  assign blank_level = (!ctrl.report && status.last_row && vsync) ? 1'b0 : blank;

endmodule

>>> src/led_grayscale_frame_serializer_top.sv
// top level: apb chip count register, sequencer and datapath
// depends on lgfs_pkg, lgfs_if, lgfs_ctrl, lgfs_datapath
//
// channel   dir   transfer when               payload
// in_ch     in    valid && ready              cmd, channel_index, level, latch_unblank,
//                                              blank_request
// out_ch    out   valid && ready              kind, frame_word, last, latch_pulse,
//                                              blank_level
// apb       in    psel && penable && pwrite   chip_count at byte address 0
//
// write and fill complete on acceptance; set blank is followed by one report
// update is followed by 6 words per active chip (chip_count clamped to 1..8), one word
//   per cycle while out_ch is ready, from the single read port of the 48-bit row store
// reset leaves the store reading zero at once, blank high and chip_count at 1
// a stalled word holds; the row store re-reads the same row until the transfer
module led_grayscale_frame_serializer_top (
  input  logic                                clk,
  input  logic                                rst,
  lgfs_in_if.sink                             in_ch,
  lgfs_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lgfs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lgfs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lgfs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import lgfs_pkg::*;

  logic [CHIP_W-1:0]    chip_count;
  logic [REG_IDX_W-1:0] reg_idx;
  ctrl_cmd_t            ctrl;
  dp_status_t           status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_count <= CHIP_W'(1);
    end else if (psel && penable && pwrite && (reg_idx == REG_CHIP_COUNT)) begin
      chip_count <= pwdata[CHIP_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_CHIP_COUNT) ? APB_DATA_W'(chip_count) : '0;

  lgfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  lgfs_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .status        (status),
    .chip_count    (chip_count),
    .channel_index (in_ch.channel_index),
    .level         (in_ch.level),
    .latch_unblank (in_ch.latch_unblank),
    .blank_request (in_ch.blank_request),
    .kind          (out_ch.kind),
    .frame_word    (out_ch.frame_word),
    .last          (out_ch.last),
    .latch_pulse   (out_ch.latch_pulse),
    .blank_level   (out_ch.blank_level)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while a result is pending");

  a_update_starts: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_UPDATE))
      |=> (out_ch.valid && !out_ch.kind))
    else $error("update did not start a frame");

  a_latch_ends: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.latch_pulse) |=> in_ch.ready)
    else $error("frame did not end after the latch word");

  a_report_blank: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_BLANK))
      |=> (out_ch.kind && (out_ch.blank_level == $past(in_ch.blank_request))))
    else $error("blank report does not match request");

endmodule
